[hdl/sqd_pkg.sv]
// ----------------------------------------------------------------------------
// sqd_pkg
// Types and constants shared by the sequenced message deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] MAX_BODY_RESET = 32'd65536;

  typedef enum logic [2:0] {
    ST_INDEX   = 3'd0,
    ST_KIND    = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_BODY    = 3'd3,
    ST_STOPPED = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    EV_BODY      = 3'd0,
    EV_HEARTBEAT = 3'd1,
    EV_EMPTY     = 3'd2,
    EV_BAD_INDEX = 3'd3,
    EV_TOO_LONG  = 3'd4
  } event_t;

  typedef struct packed {
    event_t              ev;
    logic [BYTE_W-1:0]   body;
    logic                last;
    logic [BYTE_W-1:0]   kind;
    logic [WORD_W-1:0]   len;
  } result_t;

endpackage

[hdl/sqd_in_stage.sv]
// ----------------------------------------------------------------------------
// sqd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqd_in_stage
  import sqd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [BYTE_W-1:0] s_data,
  input  logic              take,
  output logic              valid,
  output logic [BYTE_W-1:0] data
);

  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data <= s_data;
    end
  end

endmodule

[hdl/sqd_core.sv]
// ----------------------------------------------------------------------------
// sqd_core
// Frame parser: index check, type, length check and body byte pass-through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqd_core
  import sqd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  input  logic              take,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              res_valid,
  output result_t           res
);

  stage_t            stage, stage_next;
  logic [WORD_W-1:0] byte_count, byte_count_next;
  logic [WORD_W-1:0] assembly_word, assembly_word_next;
  logic [WORD_W-1:0] expected_index, expected_index_next;
  logic [BYTE_W-1:0] current_kind, current_kind_next;
  logic [WORD_W-1:0] current_length, current_length_next;
  logic [WORD_W-1:0] max_body_length;

  logic [WORD_W-1:0] word;
  logic              word_full;
  logic [WORD_W-1:0] index_inc;
  logic [WORD_W-1:0] count_inc;
  logic              body_last;

  assign word      = assembly_word
                   | ({{(WORD_W-BYTE_W){1'b0}}, data_byte} << {byte_count[1:0], 3'b000});
  assign word_full = (byte_count[1:0] == 2'd3);
  assign index_inc = expected_index + 32'd1;
  assign count_inc = byte_count + 32'd1;
  assign body_last = (count_inc >= current_length);

  always_comb begin
    stage_next          = stage;
    byte_count_next     = byte_count;
    assembly_word_next  = assembly_word;
    expected_index_next = expected_index;
    current_kind_next   = current_kind;
    current_length_next = current_length;
    res_valid           = 1'b0;
    res.ev              = EV_BODY;
    res.body            = '0;
    res.last            = 1'b0;
    res.kind            = '0;
    res.len             = '0;
    unique case (stage)
      ST_INDEX: begin
        if (word_full) begin
          assembly_word_next  = '0;
          byte_count_next     = '0;
          expected_index_next = index_inc;
          if (word != index_inc) begin
            stage_next = ST_STOPPED;
            res_valid  = 1'b1;
            res.ev     = EV_BAD_INDEX;
            res.len    = word;
          end else begin
            stage_next = ST_KIND;
          end
        end else begin
          assembly_word_next = word;
          byte_count_next    = count_inc;
        end
      end
      ST_KIND: begin
        current_kind_next  = data_byte;
        byte_count_next    = '0;
        assembly_word_next = '0;
        if (data_byte == '0) begin
          current_length_next = '0;
          stage_next          = ST_INDEX;
          res_valid           = 1'b1;
          res.ev              = EV_HEARTBEAT;
        end else begin
          stage_next = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        if (word_full) begin
          assembly_word_next  = '0;
          byte_count_next     = '0;
          current_length_next = word;
          if (word > max_body_length) begin
            stage_next = ST_STOPPED;
            res_valid  = 1'b1;
            res.ev     = EV_TOO_LONG;
            res.kind   = current_kind;
            res.len    = word;
          end else if (word == '0) begin
            stage_next = ST_INDEX;
            res_valid  = 1'b1;
            res.ev     = EV_EMPTY;
            res.kind   = current_kind;
          end else begin
            stage_next = ST_BODY;
          end
        end else begin
          assembly_word_next = word;
          byte_count_next    = count_inc;
        end
      end
      ST_BODY: begin
        res_valid = 1'b1;
        res.ev    = EV_BODY;
        res.body  = data_byte;
        res.last  = body_last;
        res.kind  = current_kind;
        res.len   = current_length;
        if (body_last) begin
          byte_count_next = '0;
          stage_next      = ST_INDEX;
        end else begin
          byte_count_next = count_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= ST_INDEX;
      byte_count     <= '0;
      assembly_word  <= '0;
      expected_index <= '0;
      current_kind   <= '0;
      current_length <= '0;
    end else if (take) begin
      stage          <= stage_next;
      byte_count     <= byte_count_next;
      assembly_word  <= assembly_word_next;
      expected_index <= expected_index_next;
      current_kind   <= current_kind_next;
      current_length <= current_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= MAX_BODY_RESET;
    end else if (cfg_wr_en) begin
      max_body_length <= cfg_wr_data;
    end
  end

`ifndef SYNTHESIS
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    stage == ST_STOPPED |=> stage == ST_STOPPED)
    else $error("left stopped stage without reset");

  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && (res.ev == EV_BAD_INDEX || res.ev == EV_TOO_LONG)
    |=> stage == ST_STOPPED)
    else $error("error reported but parser not stopped");

  a_body_only_in_body: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.ev == EV_BODY |-> stage == ST_BODY)
    else $error("body word outside body stage");

  a_word_count_small: assert property (@(posedge clk) disable iff (rst)
    (stage == ST_INDEX || stage == ST_LENGTH || stage == ST_KIND)
    |-> byte_count < 32'd4)
    else $error("header byte count out of range");

  a_body_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    stage == ST_BODY |-> current_length != '0 && byte_count < current_length)
    else $error("body count beyond length");
`endif

endmodule

[hdl/sqd_out_stage.sv]
// ----------------------------------------------------------------------------
// sqd_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqd_out_stage
  import sqd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  assign can_load = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (can_load) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      m_res <= res;
    end
  end

endmodule

[hdl/sequenced_message_deframer.sv]
// ----------------------------------------------------------------------------
// sequenced_message_deframer
// Splits a byte stream into sequenced frames and streams out body bytes.
//
// One byte is taken per clock while the result register can be loaded; each
// byte passes an input register, the frame parser and a result register;
// back-pressure on the master side stalls the slave side only when the
// result register is full. A frame is a 4-byte little-endian index (previous
// index plus one, first frame 1), a type byte (0 is a heartbeat), then for
// other types a 4-byte little-endian length checked against max_body_length
// and the body bytes, each sent as its own word with tlast on the final one.
// Index and length bytes output only bad-index, too-long or empty events. An
// index mismatch or an oversize length is reported once and the block then
// drops all input until reset. max_body_length resets to 65536; the user
// writes it via cfg_wr_en / cfg_wr_data only while idle (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequenced_message_deframer
  import sqd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] body_byte, [15:8] message_kind,
                                      // [47:16] message_length
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output logic        m_axis_tlast    // last_of_message
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_data;
  logic              take;
  logic              can_load;
  logic              res_valid;
  result_t           res;
  result_t           m_res;

  assign take = in_valid && can_load;

  sqd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .take    (take),
    .valid   (in_valid),
    .data    (in_data)
  );

  sqd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .data_byte   (in_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  sqd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && res_valid),
    .res      (res),
    .can_load (can_load),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_res    (m_res)
  );

  assign m_axis_tdata = {m_res.len, m_res.kind, m_res.body};
  assign m_axis_tuser = m_res.ev;
  assign m_axis_tlast = m_res.last;

endmodule
